// File: sv/c16x_pkg.sv
// Shared opcodes, flag layout and sequencer types for the 16-bit execute unit.
package c16x_pkg;

	typedef enum logic [4:0] {
		OP_NOP     = 5'd0,
		OP_MOV     = 5'd1,
		OP_ADD     = 5'd2,
		OP_SUB     = 5'd3,
		OP_MUL     = 5'd4,
		OP_IMUL    = 5'd5,
		OP_DIV     = 5'd6,
		OP_IDIV    = 5'd7,
		OP_CMP     = 5'd8,
		OP_AND     = 5'd9,
		OP_OR      = 5'd10,
		OP_XOR     = 5'd11,
		OP_NEG     = 5'd12,
		OP_EXTBL   = 5'd13,
		OP_EXTBH   = 5'd14,
		OP_INSBL   = 5'd15,
		OP_INSBH   = 5'd16,
		OP_SWAPB   = 5'd17,
		OP_LOAD16  = 5'd18,
		OP_LOAD8   = 5'd19,
		OP_STORE16 = 5'd20,
		OP_STORE8  = 5'd21,
		OP_JMP     = 5'd22,
		OP_JE      = 5'd23,
		OP_BRK     = 5'd24
	} op_t;

	localparam int unsigned WORD_W = 16;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned DIV_STEPS = 16;

	typedef struct packed {
		logic of;
		logic cf;
		logic sf;
		logic zf;
	} flags_t;

	typedef enum logic [1:0] {
		DU_UNSIGNED = 2'd0,
		DU_SIGNED   = 2'd1,
		DU_MUL_U    = 2'd2,
		DU_MUL_S    = 2'd3
	} du_mode_t;

	typedef struct packed {
		logic     start;
		du_mode_t mode;
	} du_ctl_t;

	typedef struct packed {
		logic done;
	} du_sts_t;

endpackage

// File: sv/c16x_ram.sv
// Generic single-port RAM with registered read.
module c16x_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// File: sv/c16x_muldiv.sv
// Shared iterative multiply and restoring-divide unit, one bit per cycle.
module c16x_muldiv (
	input  logic                  clk,
	input  logic                  arst_n,
	input  c16x_pkg::du_ctl_t     ctl,
	input  logic [15:0]           a,
	input  logic [15:0]           b,
	output c16x_pkg::du_sts_t     sts,
	output logic [15:0]           lo,
	output logic [15:0]           hi
);

	logic        busy_q;
	logic [4:0]  cnt_q;
	logic        mul_q;
	logic        neg_q_q;
	logic        neg_r_q;
	logic [15:0] acc_q;
	logic [15:0] sh_q;
	logic [15:0] b_q;
	logic        done_q;

	logic        sa;
	logic        sb;
	logic [15:0] ua;
	logic [15:0] ub;
	logic [16:0] trial;
	logic [16:0] madd;
	logic [15:0] q_fix;
	logic [15:0] r_fix;
	logic [31:0] p_fix;

	always_comb begin
		sa = (ctl.mode == c16x_pkg::DU_SIGNED || ctl.mode == c16x_pkg::DU_MUL_S) && a[15];
		sb = (ctl.mode == c16x_pkg::DU_SIGNED || ctl.mode == c16x_pkg::DU_MUL_S) && b[15];
		ua = sa ? 16'(-a) : a;
		ub = sb ? 16'(-b) : b;
		trial = {acc_q, sh_q[15]} - {1'b0, b_q};
		madd = {1'b0, acc_q} + (sh_q[0] ? {1'b0, b_q} : 17'd0);
		q_fix = neg_q_q ? 16'(-sh_q) : sh_q;
		r_fix = neg_r_q ? 16'(-acc_q) : acc_q;
		p_fix = neg_q_q ? 32'(-{acc_q, sh_q}) : {acc_q, sh_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(c16x_pkg::DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			mul_q   <= ctl.mode[1];
			neg_q_q <= sa ^ sb;
			neg_r_q <= sa;
			acc_q   <= '0;
			sh_q    <= ua;
			b_q     <= ub;
		end else if (busy_q) begin
			if (mul_q) begin
				acc_q <= madd[16:1];
				sh_q  <= {madd[0], sh_q[15:1]};
			end else if (!trial[16]) begin
				acc_q <= trial[15:0];
				sh_q  <= {sh_q[14:0], 1'b1};
			end else begin
				acc_q <= {acc_q[14:0], sh_q[15]};
				sh_q  <= {sh_q[14:0], 1'b0};
			end
		end
	end

	assign sts.done = done_q;
	assign lo = mul_q ? p_fix[15:0] : q_fix;
	assign hi = mul_q ? p_fix[31:16] : r_fix;

endmodule

// File: sv/cpu16_execute_unit.sv
// Top level of the 16-bit execute unit: register file, flags, byte RAM and sequencer.
//
//  channel | direction | handshake            | payload
//  input   | in        | in_valid / in_stall  | op use_imm src_reg dst_reg imm
//  result  | out       | out_valid/ out_stall | written_value .. fault
//
// Accept to result: simple ops and a zero divisor pass ST_EXEC and ST_DONE;
// store8 adds ST_MEM0, load8 and store16 add ST_MEM0 and ST_MEM1, load16 adds
// ST_MEM0 to ST_MEM2; mul, imul, div and idiv wait in ST_MD for the 16 one-bit
// steps of the shared multiply/divide unit. One instruction is in flight; the
// next beat can be accepted in the same cycle as the result appears if out_stall is low.
// Reset clears registers and flags; RAM holds garbage until written.
// Hold a result in the output register while out_stall is high, and stall
// the input meanwhile.
module cpu16_execute_unit #(
	parameter int unsigned NUM_REGS  = 8,
	parameter int unsigned MEM_BYTES = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [4:0]  op,
	input  logic        use_imm,
	input  logic [2:0]  src_reg,
	input  logic [2:0]  dst_reg,
	input  logic [15:0] imm,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] written_value,
	output logic [15:0] high_value,
	output logic        zero_flag,
	output logic        sign_flag,
	output logic        carry_flag,
	output logic        overflow_flag,
	output logic        branch_taken,
	output logic [15:0] branch_target,
	output logic        stop,
	output logic        fault
);

	localparam int unsigned AW = $clog2(MEM_BYTES);
	localparam int unsigned RW = $clog2(NUM_REGS);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_EXEC  = 7'b0000010,
		ST_MD    = 7'b0000100,
		ST_MEM0  = 7'b0001000,
		ST_MEM1  = 7'b0010000,
		ST_MEM2  = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	state_t state_q;

	logic [15:0] rf_q [NUM_REGS];
	c16x_pkg::flags_t flags_q;

	c16x_pkg::op_t op_q;
	logic [2:0]  dst_q;
	logic [15:0] opnd_q;
	logic [15:0] dv_q;
	logic [15:0] sv_q;
	logic [AW-1:0] addr_q;
	logic [7:0]  lo_byte_q;

	logic        res_valid_q;
	logic [15:0] wv_q;
	logic [15:0] hv_q;
	logic        taken_q;
	logic [15:0] tgt_q;
	logic        stop_q;
	logic        fault_q;

	logic        ram_we;
	logic [AW-1:0] ram_addr;
	logic [7:0]  ram_wdata;
	logic [7:0]  ram_rdata;

	c16x_pkg::du_ctl_t du_ctl;
	c16x_pkg::du_sts_t du_sts;
	logic [15:0] du_lo;
	logic [15:0] du_hi;

	logic        accept;
	logic [15:0] rd_s;
	logic [15:0] rd_d;
	logic [15:0] opnd_in;
	logic [15:0] wv;
	logic        wdst;
	logic [15:0] diff;
	logic [16:0] diff_ext;
	logic        is_md;
	logic        is_mem;
	logic        br_take;

	assign in_stall = (state_q != ST_IDLE) || (res_valid_q && out_stall);
	assign accept = in_valid && !in_stall;

	always_comb begin
		rd_s = (32'(src_reg) < NUM_REGS) ? rf_q[RW'(src_reg)] : 16'd0;
		rd_d = (32'(dst_reg) < NUM_REGS) ? rf_q[RW'(dst_reg)] : 16'd0;
		opnd_in = use_imm ? imm : rd_s;
	end

	always_comb begin
		is_md = (op_q == c16x_pkg::OP_MUL) || (op_q == c16x_pkg::OP_IMUL)
			|| (op_q == c16x_pkg::OP_DIV) || (op_q == c16x_pkg::OP_IDIV);
		is_mem = (op_q == c16x_pkg::OP_LOAD16) || (op_q == c16x_pkg::OP_LOAD8)
			|| (op_q == c16x_pkg::OP_STORE16) || (op_q == c16x_pkg::OP_STORE8);
		br_take = (op_q == c16x_pkg::OP_JMP) || (op_q == c16x_pkg::OP_JE && flags_q.zf);
		diff_ext = {1'b0, dv_q} - {1'b0, opnd_q};
		diff = diff_ext[15:0];
		wdst = 1'b1;
		case (op_q)
			c16x_pkg::OP_MOV:   wv = opnd_q;
			c16x_pkg::OP_ADD:   wv = dv_q + opnd_q;
			c16x_pkg::OP_SUB:   wv = diff;
			c16x_pkg::OP_AND:   wv = dv_q & opnd_q;
			c16x_pkg::OP_OR:    wv = dv_q | opnd_q;
			c16x_pkg::OP_XOR:   wv = dv_q ^ opnd_q;
			c16x_pkg::OP_NEG:   wv = 16'(-dv_q);
			c16x_pkg::OP_EXTBL: wv = {8'd0, opnd_q[7:0]};
			c16x_pkg::OP_EXTBH: wv = {8'd0, opnd_q[15:8]};
			c16x_pkg::OP_INSBL: wv = {dv_q[15:8], opnd_q[7:0]};
			c16x_pkg::OP_INSBH: wv = {opnd_q[7:0], dv_q[7:0]};
			c16x_pkg::OP_SWAPB: wv = {dv_q[7:0], dv_q[15:8]};
			default: begin
				wv = 16'd0;
				wdst = 1'b0;
			end
		endcase
	end

	always_comb begin
		du_ctl.start = (state_q == ST_EXEC) && is_md
			&& !((op_q == c16x_pkg::OP_DIV || op_q == c16x_pkg::OP_IDIV) && opnd_q == 16'd0);
		case (op_q)
			c16x_pkg::OP_MUL:  du_ctl.mode = c16x_pkg::DU_MUL_U;
			c16x_pkg::OP_IMUL: du_ctl.mode = c16x_pkg::DU_MUL_S;
			c16x_pkg::OP_IDIV: du_ctl.mode = c16x_pkg::DU_SIGNED;
			default:           du_ctl.mode = c16x_pkg::DU_UNSIGNED;
		endcase
	end

	always_comb begin
		ram_we = 1'b0;
		ram_addr = addr_q;
		ram_wdata = sv_q[7:0];
		if (state_q == ST_MEM0) begin
			ram_we = (op_q == c16x_pkg::OP_STORE16) || (op_q == c16x_pkg::OP_STORE8);
		end else if (state_q == ST_MEM1) begin
			ram_addr = addr_q + AW'(1);
			ram_we = (op_q == c16x_pkg::OP_STORE16);
			ram_wdata = sv_q[15:8];
		end
	end

	c16x_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	c16x_muldiv u_md (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (du_ctl),
		.a     (dv_q),
		.b     (opnd_q),
		.sts   (du_sts),
		.lo    (du_lo),
		.hi    (du_hi)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= c16x_pkg::op_t'(op);
			dst_q     <= dst_reg;
			opnd_q    <= opnd_in;
			dv_q      <= rd_d;
			sv_q      <= rd_s;
			if (op == 5'(c16x_pkg::OP_STORE16) || op == 5'(c16x_pkg::OP_STORE8)) begin
				addr_q <= AW'(use_imm ? imm : rd_d);
			end else begin
				addr_q <= AW'(use_imm ? imm : rd_s);
			end
		end
		if (state_q == ST_MEM1) begin
			lo_byte_q <= ram_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			flags_q     <= '0;
			res_valid_q <= 1'b0;
			for (int i = 0; i < NUM_REGS; i++) begin
				rf_q[i] <= '0;
			end
			wv_q    <= '0;
			hv_q    <= '0;
			taken_q <= 1'b0;
			tgt_q   <= '0;
			stop_q  <= 1'b0;
			fault_q <= 1'b0;
		end else begin
			if (res_valid_q && !out_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					wv_q    <= wv;
					hv_q    <= '0;
					taken_q <= br_take;
					tgt_q   <= br_take ? opnd_q : 16'd0;
					stop_q  <= (op_q == c16x_pkg::OP_BRK);
					fault_q <= is_md && !du_ctl.start;
					if (op_q == c16x_pkg::OP_CMP) begin
						flags_q.zf <= (diff == 16'd0);
						flags_q.sf <= diff[15];
						flags_q.cf <= diff_ext[16];
						flags_q.of <= (opnd_q[15] ^ dv_q[15]) & (dv_q[15] ^ diff[15]);
					end
					if (wdst && 32'(dst_q) < NUM_REGS) begin
						rf_q[RW'(dst_q)] <= wv;
					end
					if (is_md) begin
						state_q <= du_ctl.start ? ST_MD : ST_DONE;
					end else if (is_mem) begin
						state_q <= ST_MEM0;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_MD: begin
					if (du_sts.done) begin
						wv_q    <= du_lo;
						hv_q    <= du_hi;
						rf_q[1] <= du_lo;
						rf_q[0] <= du_hi;
						state_q <= ST_DONE;
					end
				end
				ST_MEM0: begin
					if (op_q == c16x_pkg::OP_STORE8) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_MEM1;
					end
				end
				ST_MEM1: begin
					if (op_q == c16x_pkg::OP_LOAD8) begin
						wv_q <= {8'd0, ram_rdata};
						if (32'(dst_q) < NUM_REGS) begin
							rf_q[RW'(dst_q)] <= {8'd0, ram_rdata};
						end
						state_q <= ST_DONE;
					end else if (op_q == c16x_pkg::OP_STORE16) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_MEM2;
					end
				end
				ST_MEM2: begin
					wv_q <= {ram_rdata, lo_byte_q};
					if (32'(dst_q) < NUM_REGS) begin
						rf_q[RW'(dst_q)] <= {ram_rdata, lo_byte_q};
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					res_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid     = res_valid_q;
	assign written_value = wv_q;
	assign high_value    = hv_q;
	assign zero_flag     = flags_q.zf;
	assign sign_flag     = flags_q.sf;
	assign carry_flag    = flags_q.cf;
	assign overflow_flag = flags_q.of;
	assign branch_taken  = taken_q;
	assign branch_target = tgt_q;
	assign stop          = stop_q;
	assign fault         = fault_q;

endmodule

// File: bench/cpu16_execute_unit_tb.sv
// Self-checking testbench for the 16-bit execute unit with its own instruction predictor.
module cpu16_execute_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [15:0]      wv;
		logic [15:0]      hv;
		c16x_pkg::flags_t fl;
		logic             taken;
		logic [15:0]      target;
		logic             stp;
		logic             flt;
	} exec_result_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [4:0]  op = c16x_pkg::OP_NOP;
	logic        use_imm = 0;
	logic [2:0]  src_reg = 0;
	logic [2:0]  dst_reg = 0;
	logic [15:0] imm = 0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [15:0] written_value;
	logic [15:0] high_value;
	logic        zero_flag;
	logic        sign_flag;
	logic        carry_flag;
	logic        overflow_flag;
	logic        branch_taken;
	logic [15:0] branch_target;
	logic        stop;
	logic        fault;

	logic [15:0]      regs [8];
	c16x_pkg::flags_t flags;
	bit   [7:0]       ram [int];
	int               ram_addrs [$];
	exec_result_t     results_due [$];
	int               errors = 0;
	int               sent = 0;
	int               checked = 0;
	int               cycles = 0;
	int               burst_left = 0;
	int               hold_left = 0;
	bit   [31:0]      ops_seen = 0;

	cpu16_execute_unit dut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 600000) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic exec_result_t execute(input logic [4:0] code, input logic sel,
			input logic [2:0] s, input logic [2:0] d, input logic [15:0] k);
		exec_result_t r;
		logic [15:0] opnd, dv, a, v, ua, ub, q, rm, diff;
		logic [31:0] p;
		int sa, sb;
		bit wdst;
		opnd = sel ? k : regs[s];
		dv = regs[d];
		r = '{default: 0};
		wdst = 0;
		case (c16x_pkg::op_t'(code))
			c16x_pkg::OP_MOV: begin r.wv = opnd; wdst = 1; end
			c16x_pkg::OP_ADD: begin r.wv = dv + opnd; wdst = 1; end
			c16x_pkg::OP_SUB: begin r.wv = dv - opnd; wdst = 1; end
			c16x_pkg::OP_MUL, c16x_pkg::OP_IMUL: begin
				if (code == c16x_pkg::OP_MUL) p = 32'(dv) * 32'(opnd);
				else begin
					sa = int'($signed(dv));
					sb = int'($signed(opnd));
					p = 32'(sa * sb);
				end
				r.wv = p[15:0];
				r.hv = p[31:16];
				regs[1] = r.wv;
				regs[0] = r.hv;
			end
			c16x_pkg::OP_DIV, c16x_pkg::OP_IDIV: begin
				if (opnd == 0) r.flt = 1;
				else begin
					if (code == c16x_pkg::OP_DIV) begin
						q = dv / opnd;
						rm = dv % opnd;
					end else begin
						ua = dv[15] ? -dv : dv;
						ub = opnd[15] ? -opnd : opnd;
						q = ua / ub;
						rm = ua % ub;
						if (dv[15] != opnd[15]) q = -q;
						if (dv[15]) rm = -rm;
					end
					r.wv = q;
					r.hv = rm;
					regs[1] = q;
					regs[0] = rm;
				end
			end
			c16x_pkg::OP_CMP: begin
				diff = dv - opnd;
				flags.zf = (diff == 0);
				flags.sf = diff[15];
				flags.cf = (dv < opnd);
				flags.of = (opnd[15] ^ dv[15]) & (dv[15] ^ diff[15]);
			end
			c16x_pkg::OP_AND: begin r.wv = dv & opnd; wdst = 1; end
			c16x_pkg::OP_OR: begin r.wv = dv | opnd; wdst = 1; end
			c16x_pkg::OP_XOR: begin r.wv = dv ^ opnd; wdst = 1; end
			c16x_pkg::OP_NEG: begin r.wv = -dv; wdst = 1; end
			c16x_pkg::OP_EXTBL: begin r.wv = {8'h00, opnd[7:0]}; wdst = 1; end
			c16x_pkg::OP_EXTBH: begin r.wv = {8'h00, opnd[15:8]}; wdst = 1; end
			c16x_pkg::OP_INSBL: begin r.wv = {dv[15:8], opnd[7:0]}; wdst = 1; end
			c16x_pkg::OP_INSBH: begin r.wv = {opnd[7:0], dv[7:0]}; wdst = 1; end
			c16x_pkg::OP_SWAPB: begin r.wv = {dv[7:0], dv[15:8]}; wdst = 1; end
			c16x_pkg::OP_LOAD16, c16x_pkg::OP_LOAD8: begin
				a = sel ? k : regs[s];
				r.wv = {8'h00, ram[int'(a)]};
				if (code == c16x_pkg::OP_LOAD16) r.wv[15:8] = ram[int'(16'(a + 1))];
				wdst = 1;
			end
			c16x_pkg::OP_STORE16, c16x_pkg::OP_STORE8: begin
				a = sel ? k : dv;
				v = regs[s];
				if (!ram.exists(int'(a))) ram_addrs.push_back(int'(a));
				ram[int'(a)] = v[7:0];
				if (code == c16x_pkg::OP_STORE16) begin
					a = a + 1;
					if (!ram.exists(int'(a))) ram_addrs.push_back(int'(a));
					ram[int'(a)] = v[15:8];
				end
			end
			c16x_pkg::OP_JMP: begin r.taken = 1; r.target = opnd; end
			c16x_pkg::OP_JE: if (flags.zf) begin r.taken = 1; r.target = opnd; end
			c16x_pkg::OP_BRK: r.stp = 1;
			default: ;
		endcase
		if (wdst) regs[d] = r.wv;
		r.fl = flags;
		return r;
	endfunction

	task automatic issue(input logic [4:0] code, input logic sel, input logic [2:0] s,
			input logic [2:0] d, input logic [15:0] k);
		int gap;
		bit ok;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
		end
		burst_left--;
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		op = code;
		use_imm = sel;
		src_reg = s;
		dst_reg = d;
		imm = k;
		in_valid = 1;
		forever begin
			#1 ok = !in_stall;
			@(posedge clk);
			if (ok) break;
			@(negedge clk);
		end
		results_due.push_back(execute(code, sel, s, d, k));
		ops_seen[code] = 1;
		sent++;
	endtask

	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_stall = 1;
		end else case ((cycles / 97) % 3)
			0: out_stall = 0;
			1: out_stall = 1'($urandom_range(0, 1));
			default: out_stall = ($urandom_range(0, 3) == 0);
		endcase
	end

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (results_due.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
			end else begin
				exec_result_t e;
				e = results_due.pop_front();
				checked++;
				if (written_value !== e.wv) begin
					$error("written_value exp %h got %h", e.wv, written_value); errors++; end
				if (high_value !== e.hv) begin
					$error("high_value exp %h got %h", e.hv, high_value); errors++; end
				if (zero_flag !== e.fl.zf) begin
					$error("zero_flag exp %b got %b", e.fl.zf, zero_flag); errors++; end
				if (sign_flag !== e.fl.sf) begin
					$error("sign_flag exp %b got %b", e.fl.sf, sign_flag); errors++; end
				if (carry_flag !== e.fl.cf) begin
					$error("carry_flag exp %b got %b", e.fl.cf, carry_flag); errors++; end
				if (overflow_flag !== e.fl.of) begin
					$error("overflow_flag exp %b got %b", e.fl.of, overflow_flag); errors++; end
				if (branch_taken !== e.taken) begin
					$error("branch_taken exp %b got %b", e.taken, branch_taken); errors++; end
				if (branch_target !== e.target) begin
					$error("branch_target exp %h got %h", e.target, branch_target); errors++; end
				if (stop !== e.stp) begin
					$error("stop exp %b got %b", e.stp, stop); errors++; end
				if (fault !== e.flt) begin
					$error("fault exp %b got %b", e.flt, fault); errors++; end
			end
		end
	end

	task automatic test_arith_extremes;
		issue(c16x_pkg::OP_MOV, 1, 0, 2, 16'hFFFF);
		issue(c16x_pkg::OP_MOV, 1, 0, 3, 16'h8000);
		issue(c16x_pkg::OP_ADD, 0, 2, 2, 0);
		issue(c16x_pkg::OP_SUB, 1, 0, 4, 16'h0001);
		issue(c16x_pkg::OP_MUL, 0, 2, 2, 0);
		issue(c16x_pkg::OP_IMUL, 0, 3, 3, 0);
		issue(c16x_pkg::OP_DIV, 1, 0, 2, 16'h0000);
		issue(c16x_pkg::OP_MOV, 1, 0, 5, 16'hFFFF);
		issue(c16x_pkg::OP_MOV, 1, 0, 6, 16'h8000);
		issue(c16x_pkg::OP_IDIV, 0, 5, 6, 0);
		issue(c16x_pkg::OP_IDIV, 1, 0, 5, 16'h0007);
		issue(c16x_pkg::OP_DIV, 1, 0, 5, 16'h0007);
		issue(c16x_pkg::OP_NEG, 1, 7, 6, 16'h1234);
	endtask

	task automatic test_flags_branches;
		issue(c16x_pkg::OP_CMP, 1, 0, 6, 16'h8000);
		issue(c16x_pkg::OP_JE, 1, 0, 0, 16'hFFFF);
		issue(c16x_pkg::OP_CMP, 1, 0, 6, 16'h0001);
		issue(c16x_pkg::OP_JE, 0, 5, 0, 0);
		issue(c16x_pkg::OP_JMP, 0, 5, 0, 0);
		issue(c16x_pkg::OP_BRK, 0, 0, 0, 0);
		issue(5'd25, 1, 7, 7, 16'hFFFF);
		issue(5'd31, 0, 0, 0, 0);
	endtask

	task automatic test_bytes_memory;
		issue(c16x_pkg::OP_MOV, 1, 0, 1, 16'hA55A);
		issue(c16x_pkg::OP_XOR, 1, 0, 1, 16'hFF00);
		issue(c16x_pkg::OP_EXTBH, 0, 1, 2, 0);
		issue(c16x_pkg::OP_INSBL, 1, 0, 1, 16'h00C3);
		issue(c16x_pkg::OP_INSBH, 1, 0, 1, 16'h003C);
		issue(c16x_pkg::OP_SWAPB, 1, 0, 1, 0);
		issue(c16x_pkg::OP_STORE16, 1, 1, 0, 16'hFFFF);
		issue(c16x_pkg::OP_LOAD16, 1, 0, 4, 16'hFFFF);
		issue(c16x_pkg::OP_STORE8, 1, 5, 0, 16'h0010);
		issue(c16x_pkg::OP_LOAD8, 1, 0, 3, 16'h0010);
		issue(c16x_pkg::OP_AND, 0, 4, 4, 0);
		issue(c16x_pkg::OP_OR, 1, 0, 4, 16'h0F0F);
		issue(c16x_pkg::OP_EXTBL, 1, 0, 4, 16'hFFFF);
	endtask

	task automatic random_instr;
		logic [4:0] code;
		logic sel;
		logic [2:0] s, d;
		logic [15:0] k, a;
		code = ($urandom_range(0, 15) == 0) ? 5'($urandom_range(0, 31))
			: 5'($urandom_range(c16x_pkg::OP_MOV, c16x_pkg::OP_BRK));
		sel = 1'($urandom_range(0, 1));
		s = 3'($urandom_range(0, 7));
		d = 3'($urandom_range(0, 7));
		case ($urandom_range(0, 3))
			0: k = 16'($urandom);
			1: k = 16'($urandom_range(0, 255));
			2: k = 16'(16'hFFFF - $urandom_range(0, 3));
			default: k = 16'($urandom_range(0, 3));
		endcase
		if (code == c16x_pkg::OP_STORE16 || code == c16x_pkg::OP_STORE8) begin
			if ($urandom_range(0, 3) != 0) begin
				sel = 1;
				k = ($urandom_range(0, 15) == 0) ? 16'hFFFF : 16'($urandom_range(0, 63));
			end
		end else if (code == c16x_pkg::OP_LOAD16 || code == c16x_pkg::OP_LOAD8) begin
			a = sel ? k : regs[s];
			if (!ram.exists(int'(a)) ||
					(code == c16x_pkg::OP_LOAD16 && !ram.exists(int'(16'(a + 1))))) begin
				sel = 1;
				if (ram_addrs.size() == 0) code = c16x_pkg::OP_STORE16;
				else begin
					k = 16'(ram_addrs[$urandom_range(0, ram_addrs.size() - 1)]);
					if (!ram.exists(int'(16'(k + 1)))) code = c16x_pkg::OP_LOAD8;
				end
			end
		end
		issue(code, sel, s, d, k);
	endtask

	task automatic test_random(input int count);
		repeat (count) random_instr();
	endtask

	task automatic test_output_hold;
		hold_left = 300;
		repeat (40) random_instr();
	endtask

	initial begin
		foreach (regs[i]) regs[i] = 0;
		flags = '0;
		repeat (5) @(negedge clk);
		arst_n = 1;
		test_arith_extremes();
		test_flags_branches();
		test_bytes_memory();
		test_random(800);
		test_output_hold();
		test_random(860);
		@(negedge clk);
		in_valid = 0;
		while (results_due.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("Executed %0d instructions, checked %0d results, opcode set %h.",
			sent, checked, ops_seen);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
